// ===== sv/dds_pkg.sv =====
package dds_pkg;

   // field widths
   localparam int CFG_W      = 5;
   localparam int ACT_W      = 3;
   localparam int WIDX_W     = 4;
   localparam int WVAL_W     = 16;
   localparam int RAND_W     = 16;
   localparam int CAT_W      = 4;
   localparam int CSUM_W     = 32;
   localparam int SSUM_W     = 48;
   localparam int MEAN_W     = 24;
   localparam int VAR_W      = 40;
   localparam int VD_W       = 16;
   localparam int CNT_VAL_W  = 16;
   localparam int Q_FRAC     = 8;

   // at most this many categories take part in sampling and reports
   localparam int MAX_REPORT = 16;
   localparam int TOT_W      = WVAL_W + $clog2(MAX_REPORT);
   localparam int DVD_W      = SSUM_W + Q_FRAC;

   localparam int NUM_CATEGORIES_DEF = 16;
   localparam int RANDOM_BITS_DEF    = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_END    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_REPORT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [VD_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/dds_channels.sv =====
interface dds_req_if;
   import dds_pkg::*;
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [WIDX_W-1:0] weight_index;
   logic [WVAL_W-1:0] weight_value;
   logic [RAND_W-1:0] random_value;

   modport source (output valid, action, weight_index, weight_value, random_value,
                   input ready);
   modport sink   (input valid, action, weight_index, weight_value, random_value,
                   output ready);
endinterface

interface dds_rsp_if;
   import dds_pkg::*;
   logic              valid;
   logic              ready;
   logic [CAT_W-1:0]  category;
   logic [CSUM_W-1:0] count_total;
   logic [SSUM_W-1:0] square_total;
   logic [MEAN_W-1:0] mean_q8;
   logic [VAR_W-1:0]  variance_q8;
   logic              last;

   modport source (output valid, category, count_total, square_total, mean_q8,
                   variance_q8, last, input ready);
   modport sink   (input valid, category, count_total, square_total, mean_q8,
                   variance_q8, last, output ready);
endinterface

interface dds_csr_if;
   import dds_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] category_count;

   modport source (output valid, category_count, input ready);
   modport sink   (input valid, category_count, output ready);
endinterface

// ===== sv/dds_div.sv =====
module dds_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dds_pkg::div_req_type div_req,
   output dds_pkg::div_rsp_type div_rsp
);
   import dds_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VD_W-1:0]   rem_ff, rem_in;
   logic [VD_W-1:0]   dsr_ff, dsr_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;

   logic [VD_W:0]     rem_sh;
   logic [VD_W:0]     diff;
   logic              ge;

   // restoring division, one quotient bit per cycle; dividend shifts out of
   // quo_ff as the quotient shifts in
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign ge     = ~diff[VD_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         rem_in  = ge ? diff[VD_W-1:0] : rem_sh[VD_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== sv/discrete_distribution_sampler_core.sv =====
// Discrete distribution sampler.
// req_ch carries one request: load a weight, draw a sample, end a vector,
// report, or clear statistics. rsp_ch returns results; last marks the final
// result of a request. csr_ch writes category_count (1..16); the user must do
// that only while idle, as the block does not enforce it. req_ch.ready is high
// only while the sequencer is idle; one request at a time. Per request:
//   load, clear, end vector with vector counter full: stay idle, no result.
//   sample: two passes of the shared adder over the weight memory (total,
//     then cumulative compare), then a count update; the compare pass is
//     skipped when the total weight is zero.
//   end vector: NUM_CATEGORIES entries, one entry a cycle through the sums.
//   report: one result per category, the bit-serial divider doing mean and
//     mean square for each; the divider is skipped with no vectors done.
// Reset clears the sequencer and all valid bits, so every table reads as zero
// at once (no clearing pass); category_count returns to 16.
// Results sit in an output register. A stalled receiver holds that register;
// a sample whose result finds it still full waits there before going idle,
// and a report waits for each slot before producing its next category.
module discrete_distribution_sampler_core #(
   parameter int NUM_CATEGORIES = dds_pkg::NUM_CATEGORIES_DEF,
   parameter int RANDOM_BITS    = dds_pkg::RANDOM_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   dds_req_if.sink    req_ch,
   dds_rsp_if.source  rsp_ch,
   dds_csr_if.sink    csr_ch
);
   import dds_pkg::*;

   localparam int IDX_W   = $clog2(NUM_CATEGORIES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int TOP_CAT = (NUM_CATEGORIES < MAX_REPORT) ? NUM_CATEGORIES : MAX_REPORT;
   localparam int PROD_W  = RAND_W + TOT_W;
   localparam int CMP_W   = (PROD_W > TOT_W + RANDOM_BITS) ? PROD_W : TOT_W + RANDOM_BITS;
   localparam int ST_W    = 4;

   localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] S_SUM     = 4'd1;
   localparam logic [ST_W-1:0] S_MUL     = 4'd2;
   localparam logic [ST_W-1:0] S_SCAN    = 4'd3;
   localparam logic [ST_W-1:0] S_INC_RD  = 4'd4;
   localparam logic [ST_W-1:0] S_INC_WR  = 4'd5;
   localparam logic [ST_W-1:0] S_SOUT    = 4'd6;
   localparam logic [ST_W-1:0] S_EV      = 4'd7;
   localparam logic [ST_W-1:0] S_REP_RD  = 4'd8;
   localparam logic [ST_W-1:0] S_REP_DAT = 4'd9;
   localparam logic [ST_W-1:0] S_DIV_M   = 4'd10;
   localparam logic [ST_W-1:0] S_DIV_S   = 4'd11;
   localparam logic [ST_W-1:0] S_REP_OUT = 4'd12;

   // control
   logic [ST_W-1:0]           state_ff, state_in;
   logic [CFG_W-1:0]          cfg_ff, cfg_in;
   logic [VD_W-1:0]           vd_ff, vd_in;
   logic [CNT_W-1:0]          ra_ff, ra_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      ev_wr_ff, ev_wr_in;
   logic [NUM_CATEGORIES-1:0] weight_vld_ff, weight_vld_in;
   logic [NUM_CATEGORIES-1:0] cnt_vld_ff, cnt_vld_in;
   logic [NUM_CATEGORIES-1:0] sum_vld_ff, sum_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [TOT_W-1:0]          acc_ff, acc_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [RAND_W-1:0]         rand_ff, rand_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   logic [IDX_W-1:0]          ev_idx_ff, ev_idx_in;
   logic [CNT_VAL_W-1:0]      ev_c_ff, ev_c_in;
   logic [2*CNT_VAL_W-1:0]    sq_ff, sq_in;
   logic [CSUM_W-1:0]         ev_cs_ff, ev_cs_in;
   logic [SSUM_W-1:0]         ev_ss_ff, ev_ss_in;
   logic [CSUM_W-1:0]         rep_cs_ff, rep_cs_in;
   logic [SSUM_W-1:0]         rep_ss_ff, rep_ss_in;
   logic [MEAN_W-1:0]         mean_ff, mean_in;
   logic [VAR_W-1:0]          m2_ff, m2_in;
   logic [VAR_W-1:0]          var_ff, var_in;
   logic [CAT_W-1:0]          rsp_cat_ff, rsp_cat_in;
   logic [CSUM_W-1:0]         rsp_cs_ff, rsp_cs_in;
   logic [SSUM_W-1:0]         rsp_ss_ff, rsp_ss_in;
   logic [MEAN_W-1:0]         rsp_mean_ff, rsp_mean_in;
   logic [VAR_W-1:0]          rsp_var_ff, rsp_var_in;
   logic                      rsp_last_ff, rsp_last_in;

   // memories and registered read ports
   logic [WVAL_W-1:0]    weight_mem [NUM_CATEGORIES];
   logic [CNT_VAL_W-1:0] cnt_mem    [NUM_CATEGORIES];
   logic [CSUM_W-1:0]    csum_mem   [NUM_CATEGORIES];
   logic [SSUM_W-1:0]    ssum_mem   [NUM_CATEGORIES];
   logic [WVAL_W-1:0]    w_q_ff;
   logic [CNT_VAL_W-1:0] c_q_ff;
   logic [CSUM_W-1:0]    cs_q_ff;
   logic [SSUM_W-1:0]    ss_q_ff;
   logic                 wv_q_ff, cv_q_ff, sv_q_ff;

   logic [IDX_W-1:0]     rd_addr;
   logic                 wt_we;
   logic [IDX_W-1:0]     wt_addr;
   logic                 cnt_we;
   logic [CNT_VAL_W-1:0] cnt_wdata;
   logic                 sum_we;
   logic [CSUM_W-1:0]    cs_wdata;
   logic [SSUM_W-1:0]    ss_wdata;
   logic                 cnt_clear, sum_clear;
   logic                 issue;
   logic                 rsp_load;

   logic                 req_fire;
   logic                 slot_free;
   logic [CNT_W-1:0]     n_act;
   logic [IDX_W-1:0]     n_m1;
   logic [WVAL_W-1:0]    w_eff;
   logic [CNT_VAL_W-1:0] c_eff;
   logic [CSUM_W-1:0]    cs_eff;
   logic [SSUM_W-1:0]    ss_eff;
   logic [TOT_W-1:0]     cum;
   logic                 hit;
   logic [CSUM_W:0]      cs_sum;
   logic [SSUM_W:0]      ss_sum;
   logic [2*MEAN_W-1:0]  mean_sq;
   logic [DVD_W-1:0]     msq_diff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   dds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (cfg_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (int'(cfg_ff) > TOP_CAT) begin
         n_act = CNT_W'(TOP_CAT);
      end else begin
         n_act = CNT_W'(cfg_ff);
      end
   end
   assign n_m1 = IDX_W'(n_act - CNT_W'(1));

   // entries not written since reset (counts and sums: since their last clear) read as zero
   assign w_eff  = wv_q_ff ? w_q_ff : '0;
   assign c_eff  = cv_q_ff ? c_q_ff : '0;
   assign cs_eff = sv_q_ff ? cs_q_ff : '0;
   assign ss_eff = sv_q_ff ? ss_q_ff : '0;

   // r * total < cum * 2^RANDOM_BITS
   assign cum = acc_ff + TOT_W'(w_eff);
   assign hit = CMP_W'(prod_ff) < (CMP_W'(cum) << RANDOM_BITS);

   assign cs_sum   = {1'b0, ev_cs_ff} + (CSUM_W + 1)'(ev_c_ff);
   assign ss_sum   = {1'b0, ev_ss_ff} + (SSUM_W + 1)'(sq_ff);
   assign cs_wdata = cs_sum[CSUM_W] ? '1 : cs_sum[CSUM_W-1:0];
   assign ss_wdata = ss_sum[SSUM_W] ? '1 : ss_sum[SSUM_W-1:0];

   assign mean_sq  = mean_ff * mean_ff;
   assign msq_diff = div_rsp.quotient - DVD_W'(m2_ff);

   always_comb begin
      state_in    = state_ff;
      vd_in       = vd_ff;
      ra_in       = ra_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      rand_in     = rand_ff;
      pick_in     = pick_ff;
      rep_cs_in   = rep_cs_ff;
      rep_ss_in   = rep_ss_ff;
      mean_in     = mean_ff;
      m2_in       = m2_ff;
      var_in      = var_ff;
      rsp_cat_in  = rsp_cat_ff;
      rsp_cs_in   = rsp_cs_ff;
      rsp_ss_in   = rsp_ss_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_var_in  = rsp_var_ff;
      rsp_last_in = rsp_last_ff;
      rd_addr     = '0;
      issue       = 1'b0;
      wt_we       = 1'b0;
      wt_addr     = IDX_W'(req_ch.weight_index);
      cnt_we      = 1'b0;
      cnt_wdata   = (c_eff == '1) ? c_eff : c_eff + CNT_VAL_W'(1);
      sum_we      = 1'b0;
      cnt_clear   = 1'b0;
      sum_clear   = 1'b0;
      rsp_load    = 1'b0;
      div_req     = '0;

      // end-vector pipeline, stage one
      ev_wr_in  = rd_pend_ff && (state_ff == S_EV);
      ev_idx_in = rd_idx_ff;
      ev_c_in   = c_eff;
      sq_in     = c_eff * c_eff;
      ev_cs_in  = cs_eff;
      ev_ss_in  = ss_eff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.action)
                  ACT_LOAD: begin
                     wt_we = int'(req_ch.weight_index) < NUM_CATEGORIES;
                  end
                  ACT_SAMPLE: begin
                     rand_in  = req_ch.random_value;
                     ra_in    = '0;
                     acc_in   = '0;
                     state_in = S_SUM;
                  end
                  ACT_END: begin
                     if (vd_ff == '1) begin
                        cnt_clear = 1'b1;
                     end else begin
                        ra_in    = '0;
                        state_in = S_EV;
                     end
                  end
                  ACT_REPORT: begin
                     ra_in    = '0;
                     state_in = S_REP_RD;
                  end
                  ACT_CLEAR: begin
                     cnt_clear = 1'b1;
                     sum_clear = 1'b1;
                     vd_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SUM: begin
            if (ra_ff < n_act) begin
               issue   = 1'b1;
               rd_addr = ra_ff[IDX_W-1:0];
               ra_in   = ra_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               acc_in = cum;
               if (rd_idx_ff == n_m1) begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in = rand_ff * acc_ff;
            ra_in   = '0;
            if (acc_ff == '0) begin
               pick_in  = n_m1;
               state_in = S_INC_RD;
            end else begin
               acc_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ra_ff < n_act) begin
               issue   = 1'b1;
               rd_addr = ra_ff[IDX_W-1:0];
               ra_in   = ra_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               acc_in = cum;
               // no hit by the last category still picks it
               if (hit || rd_idx_ff == n_m1) begin
                  pick_in  = rd_idx_ff;
                  state_in = S_INC_RD;
               end
            end
         end
         S_INC_RD: begin
            rd_addr  = pick_ff;
            state_in = S_INC_WR;
         end
         S_INC_WR: begin
            cnt_we   = 1'b1;
            state_in = S_SOUT;
         end
         S_SOUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_cat_in  = CAT_W'(pick_ff);
               rsp_cs_in   = '0;
               rsp_ss_in   = '0;
               rsp_mean_in = '0;
               rsp_var_in  = '0;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EV: begin
            if (ra_ff < CNT_W'(NUM_CATEGORIES)) begin
               issue   = 1'b1;
               rd_addr = ra_ff[IDX_W-1:0];
               ra_in   = ra_ff + CNT_W'(1);
            end
            if (ev_wr_ff) begin
               sum_we = 1'b1;
               if (ev_idx_ff == IDX_W'(NUM_CATEGORIES - 1)) begin
                  vd_in     = vd_ff + VD_W'(1);
                  cnt_clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_REP_RD: begin
            rd_addr  = ra_ff[IDX_W-1:0];
            state_in = S_REP_DAT;
         end
         S_REP_DAT: begin
            rep_cs_in = cs_eff;
            rep_ss_in = ss_eff;
            if (vd_ff == '0) begin
               mean_in  = '0;
               var_in   = '0;
               state_in = S_REP_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'({cs_eff, {Q_FRAC{1'b0}}});
               div_req.divisor  = vd_ff;
               state_in         = S_DIV_M;
            end
         end
         S_DIV_M: begin
            if (div_rsp.done) begin
               mean_in = (|div_rsp.quotient[DVD_W-1:MEAN_W]) ? '1
                                                              : div_rsp.quotient[MEAN_W-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = {rep_ss_ff, {Q_FRAC{1'b0}}};
               div_req.divisor  = vd_ff;
               state_in         = S_DIV_S;
            end
         end
         S_DIV_S: begin
            m2_in = mean_sq[2*MEAN_W-1:Q_FRAC];
            if (div_rsp.done) begin
               if (div_rsp.quotient > DVD_W'(m2_ff)) begin
                  var_in = (|msq_diff[DVD_W-1:VAR_W]) ? '1 : msq_diff[VAR_W-1:0];
               end else begin
                  var_in = '0;
               end
               state_in = S_REP_OUT;
            end
         end
         S_REP_OUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_cat_in  = CAT_W'(ra_ff);
               rsp_cs_in   = rep_cs_ff;
               rsp_ss_in   = rep_ss_ff;
               rsp_mean_in = mean_ff;
               rsp_var_in  = var_ff;
               rsp_last_in = (ra_ff == n_act - CNT_W'(1));
               if (ra_ff == n_act - CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ra_in    = ra_ff + CNT_W'(1);
                  state_in = S_REP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_pend_in = issue;
      rd_idx_in  = issue ? ra_ff[IDX_W-1:0] : rd_idx_ff;

      weight_vld_in = weight_vld_ff;
      if (wt_we) begin
         weight_vld_in[wt_addr] = 1'b1;
      end
      cnt_vld_in = cnt_vld_ff;
      if (cnt_clear) begin
         cnt_vld_in = '0;
      end else if (cnt_we) begin
         cnt_vld_in[pick_ff] = 1'b1;
      end
      sum_vld_in = sum_vld_ff;
      if (sum_clear) begin
         sum_vld_in = '0;
      end else if (sum_we) begin
         sum_vld_in[ev_idx_ff] = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cfg_in = csr_ch.valid ? csr_ch.category_count : cfg_ff;
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         weight_mem[wt_addr] <= req_ch.weight_value;
      end
      if (cnt_we) begin
         cnt_mem[pick_ff] <= cnt_wdata;
      end
      if (sum_we) begin
         csum_mem[ev_idx_ff] <= cs_wdata;
         ssum_mem[ev_idx_ff] <= ss_wdata;
      end
      w_q_ff  <= weight_mem[rd_addr];
      c_q_ff  <= cnt_mem[rd_addr];
      cs_q_ff <= csum_mem[rd_addr];
      ss_q_ff <= ssum_mem[rd_addr];
      wv_q_ff <= weight_vld_ff[rd_addr];
      cv_q_ff <= cnt_vld_ff[rd_addr];
      sv_q_ff <= sum_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cfg_ff        <= CFG_RESET;
         vd_ff         <= '0;
         rd_pend_ff    <= 1'b0;
         ev_wr_ff      <= 1'b0;
         weight_vld_ff <= '0;
         cnt_vld_ff    <= '0;
         sum_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         vd_ff         <= vd_in;
         rd_pend_ff    <= rd_pend_in;
         ev_wr_ff      <= ev_wr_in;
         weight_vld_ff <= weight_vld_in;
         cnt_vld_ff    <= cnt_vld_in;
         sum_vld_ff    <= sum_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ra_ff       <= ra_in;
      rd_idx_ff   <= rd_idx_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rand_ff     <= rand_in;
      pick_ff     <= pick_in;
      ev_idx_ff   <= ev_idx_in;
      ev_c_ff     <= ev_c_in;
      sq_ff       <= sq_in;
      ev_cs_ff    <= ev_cs_in;
      ev_ss_ff    <= ev_ss_in;
      rep_cs_ff   <= rep_cs_in;
      rep_ss_ff   <= rep_ss_in;
      mean_ff     <= mean_in;
      m2_ff       <= m2_in;
      var_ff      <= var_in;
      rsp_cat_ff  <= rsp_cat_in;
      rsp_cs_ff   <= rsp_cs_in;
      rsp_ss_ff   <= rsp_ss_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.category     = rsp_cat_ff;
   assign rsp_ch.count_total  = rsp_cs_ff;
   assign rsp_ch.square_total = rsp_ss_ff;
   assign rsp_ch.mean_q8      = rsp_mean_ff;
   assign rsp_ch.variance_q8  = rsp_var_ff;
   assign rsp_ch.last         = rsp_last_ff;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("sequencer not idle after reset");

   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_vd_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_ch.action == ACT_CLEAR) |=> vd_ff >= $past(vd_ff))
      else $error("vector counter dropped without a clear");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (rsp_last_in == (state_in == S_IDLE)))
      else $error("last flag does not match the end of the request");

endmodule
